// File: hdl/dic_pkg.sv
// Shared constants and types for the dual-index FIFO cache.
package dic_pkg;
  localparam int MAX_SETS   = 256;
  localparam int MAX_WAYS   = 8;
  localparam int ADDR_BITS  = 48;
  localparam int COUNT_BITS = 32;
  localparam int SET_W      = $clog2(MAX_SETS);
  localparam int WAY_W      = $clog2(MAX_WAYS);
  localparam int SET_BITS_MAX = SET_W;
  // one memory row per set: all ways' tags side by side
  localparam int ROW_W = MAX_WAYS * ADDR_BITS;
  // stored entry per set: FIFO pointer, valid bits, tag row (lowest)
  localparam int ENTRY_W = ROW_W + MAX_WAYS + WAY_W;

  localparam logic [1:0] REG_OFFSET = 2'd0;
  localparam logic [1:0] REG_SETS   = 2'd1;
  localparam logic [1:0] REG_WAYS   = 2'd2;

  typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_LOOK, ST_OUT} state_t;

  // result of one lookup in one cache
  typedef struct packed {
    logic                 hit;
    logic [MAX_WAYS-1:0]  valid_next;
    logic [WAY_W-1:0]     oldest_next;
    logic [ROW_W-1:0]     row_next;
    logic                 wr_row;
  } look_t;
endpackage

// File: hdl/dic_ram.sv
// Generic single-port RAM with registered read.
module dic_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

// File: hdl/dic_way_logic.sv
// Tag compare and FIFO victim choice for one cache set.
module dic_way_logic (
  input  logic [dic_pkg::ROW_W-1:0]    row,
  input  logic [dic_pkg::MAX_WAYS-1:0] valid,
  input  logic [dic_pkg::WAY_W-1:0]    oldest,
  input  logic [dic_pkg::ADDR_BITS-1:0] tag,
  input  logic [dic_pkg::WAY_W:0]      ways,
  output dic_pkg::look_t               res
);
  logic hit;
  logic found;
  logic [dic_pkg::WAY_W-1:0] inv_way;
  logic [dic_pkg::WAY_W-1:0] victim;
  logic [dic_pkg::WAY_W:0]   inc;

  always_comb begin
    hit = 1'b0;
    found = 1'b0;
    inv_way = '0;
    for (int w = 0; w < dic_pkg::MAX_WAYS; w++) begin
      if ((dic_pkg::WAY_W+1)'(w) < ways) begin
        if (valid[w] && row[w*dic_pkg::ADDR_BITS +: dic_pkg::ADDR_BITS] == tag) hit = 1'b1;
        if (!valid[w] && !found) begin
          found = 1'b1;
          inv_way = dic_pkg::WAY_W'(w);
        end
      end
    end
    victim = ({1'b0, oldest} >= ways) ? '0 : oldest;
    inc = {1'b0, victim} + 1'b1;
    res.hit = hit;
    res.wr_row = !hit;
    res.valid_next = valid;
    res.oldest_next = oldest;
    res.row_next = row;
    if (!hit) begin
      if (found) begin
        res.valid_next[inv_way] = 1'b1;
        res.row_next[inv_way*dic_pkg::ADDR_BITS +: dic_pkg::ADDR_BITS] = tag;
      end else begin
        res.valid_next[victim] = 1'b1;
        res.row_next[victim*dic_pkg::ADDR_BITS +: dic_pkg::ADDR_BITS] = tag;
        res.oldest_next = (inc >= ways) ? '0 : inc[dic_pkg::WAY_W-1:0];
      end
    end
  end
endmodule

// File: hdl/dual_index_fifo_cache_model.sv
// Dual-index FIFO cache: two tag-only set-associative caches looked up per request.
// Flow: a request is taken in IDLE while its tag rows are read; LOOK compares and
// writes back the rows, and OUT offers the result until it is taken.
// A new request is not taken until the last result has been handed off.
// Reset: registers go to 0, 0, 1 and counters clear at once; then a pass over all 256
// sets zeroes every set entry (tags, valid bits, FIFO pointer) with s_axis_tready held low.
module dual_index_fifo_cache_model (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [47:0]  s_axis_tdata,  // address
  input  logic         s_axis_tuser,  // opcode
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [255:0] m_axis_tdata,  // misses_a, writes_a, hits_a, misses_a,
                                      // misses_b, writes_b, hits_b, misses_b
  output logic [1:0]   m_axis_tuser,  // hit_a, hit_b
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [5:0]   cfg_data
);
  localparam int AB = dic_pkg::ADDR_BITS;
  localparam int SW = dic_pkg::SET_W;
  localparam int WW = dic_pkg::WAY_W;
  localparam int NW = dic_pkg::MAX_WAYS;
  localparam int CB = dic_pkg::COUNT_BITS;
  localparam int RW = dic_pkg::ROW_W;
  localparam int EW = dic_pkg::ENTRY_W;

  logic [5:0] offset_bits;
  logic [3:0] set_index_bits;
  logic [3:0] ways_in_use;

  dic_pkg::state_t state, state_next;
  logic          wr;
  logic [SW-1:0] set_a, set_b;
  logic [AB-1:0] tag_a, tag_b;
  logic [SW-1:0] clr_set;
  logic [CB-1:0] cnt [8];
  logic          hit_a, hit_b;

  logic [6:0] o_eff;
  logic [3:0] s_eff;
  logic [WW:0] ways;
  logic [AB-1:0] mask_s, mask_t, sh_o;
  logic [SW-1:0] in_set_a, in_set_b;
  logic [EW-1:0] ent_a, ent_b, wdata_a, wdata_b;
  logic [SW-1:0] ram_addr_a, ram_addr_b;
  logic          ram_we_a, ram_we_b;
  dic_pkg::look_t res_a, res_b;
  logic we;
  logic clearing;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      offset_bits <= '0; set_index_bits <= '0; ways_in_use <= 4'd1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        dic_pkg::REG_OFFSET: offset_bits <= cfg_data;
        dic_pkg::REG_SETS:   set_index_bits <= cfg_data[3:0];
        dic_pkg::REG_WAYS:   ways_in_use <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [6:0] room;
    o_eff = (offset_bits > 6'(AB)) ? 7'(AB) : {1'b0, offset_bits};
    s_eff = (set_index_bits > 4'(dic_pkg::SET_BITS_MAX)) ? 4'(dic_pkg::SET_BITS_MAX)
                                                         : set_index_bits;
    room = 7'(AB) - o_eff;
    if ({3'b0, s_eff} > room) s_eff = room[3:0];
    if (ways_in_use == 4'd0) ways = (WW+1)'(1);
    else if (ways_in_use > 4'(NW)) ways = (WW+1)'(NW);
    else ways = ways_in_use[WW:0];
    mask_s = ~({AB{1'b1}} << s_eff);
    mask_t = ~({AB{1'b1}} << (7'(AB) - o_eff - {3'b0, s_eff}));
    sh_o = s_axis_tdata >> o_eff;
  end

  assign in_set_a = SW'(sh_o & mask_s);
  assign in_set_b = SW'((s_axis_tdata >> (7'(AB) - {3'b0, s_eff})) & mask_s);

  always_comb begin
    state_next = state;
    s_axis_tready = 1'b0;
    m_axis_tvalid = 1'b0;
    we = 1'b0;
    clearing = 1'b0;
    unique case (state)
      dic_pkg::ST_CLEAR: begin
        clearing = 1'b1;
        if (clr_set == SW'(dic_pkg::MAX_SETS - 1)) state_next = dic_pkg::ST_IDLE;
      end
      dic_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) state_next = dic_pkg::ST_LOOK;
      end
      dic_pkg::ST_LOOK: begin
        we = 1'b1;
        state_next = dic_pkg::ST_OUT;
      end
      dic_pkg::ST_OUT: begin
        m_axis_tvalid = 1'b1;
        if (m_axis_tready) state_next = dic_pkg::ST_IDLE;
      end
      default: state_next = dic_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= dic_pkg::ST_CLEAR;
    else state <= state_next;
  end

  // sweep over all sets after reset
  always_ff @(posedge clk) begin
    if (rst) clr_set <= '0;
    else if (clearing) clr_set <= clr_set + 1'b1;
  end

  // request capture: opcode, set and tag of both caches
  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      wr    <= s_axis_tuser;
      set_a <= in_set_a;
      tag_a <= (sh_o >> s_eff) & mask_t;
      set_b <= in_set_b;
      tag_b <= sh_o & mask_t;
    end
  end

  assign ram_we_a   = clearing || (we && res_a.wr_row);
  assign ram_we_b   = clearing || (we && res_b.wr_row);
  assign ram_addr_a = clearing ? clr_set : (we ? set_a : in_set_a);
  assign ram_addr_b = clearing ? clr_set : (we ? set_b : in_set_b);
  assign wdata_a    = clearing ? '0 : {res_a.oldest_next, res_a.valid_next, res_a.row_next};
  assign wdata_b    = clearing ? '0 : {res_b.oldest_next, res_b.valid_next, res_b.row_next};

  dic_ram #(.WIDTH(EW), .DEPTH(dic_pkg::MAX_SETS)) u_tags_a (
    .clk(clk), .we(ram_we_a), .addr(ram_addr_a), .wdata(wdata_a), .rdata(ent_a));
  dic_ram #(.WIDTH(EW), .DEPTH(dic_pkg::MAX_SETS)) u_tags_b (
    .clk(clk), .we(ram_we_b), .addr(ram_addr_b), .wdata(wdata_b), .rdata(ent_b));

  dic_way_logic u_look_a (.row(ent_a[RW-1:0]), .valid(ent_a[RW +: NW]),
    .oldest(ent_a[RW+NW +: WW]), .tag(tag_a), .ways(ways), .res(res_a));
  dic_way_logic u_look_b (.row(ent_b[RW-1:0]), .valid(ent_b[RW +: NW]),
    .oldest(ent_b[RW+NW +: WW]), .tag(tag_b), .ways(ways), .res(res_b));

  function automatic logic [CB-1:0] sat_inc(input logic [CB-1:0] v, input logic en);
    sat_inc = (en && v != {CB{1'b1}}) ? v + 1'b1 : v;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 8; k++) cnt[k] <= '0;
    end else if (we) begin
      cnt[0] <= sat_inc(cnt[0], !res_a.hit);
      cnt[1] <= sat_inc(cnt[1], wr);
      cnt[2] <= sat_inc(cnt[2], res_a.hit);
      cnt[3] <= sat_inc(cnt[3], !res_a.hit);
      cnt[4] <= sat_inc(cnt[4], !res_b.hit);
      cnt[5] <= sat_inc(cnt[5], wr);
      cnt[6] <= sat_inc(cnt[6], res_b.hit);
      cnt[7] <= sat_inc(cnt[7], !res_b.hit);
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      hit_a <= res_a.hit;
      hit_b <= res_b.hit;
    end
  end

  assign m_axis_tuser = {hit_b, hit_a};
  assign m_axis_tdata = {cnt[7], cnt[6], cnt[5], cnt[4], cnt[3], cnt[2], cnt[1], cnt[0]};
endmodule
